// ===== design/utf8_to_ucs2_decoder_top_assert.svh =====
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder_top_assert.svh
// assertion macros shared by the decoder rtl files
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UCS2_DECODER_TOP_ASSERT_SVH
`define UTF8_TO_UCS2_DECODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked at every rising edge out of reset
`define U8DEC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("u8dec assertion failed");

// next-cycle implication
`define U8DEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("u8dec assertion failed");

`else

`define U8DEC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define U8DEC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/u8dec_pkg.sv =====
// ----------------------------------------------------------------------------
// u8dec_pkg
// types and constants of the utf-8 to ucs-2 decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8dec_pkg;

    localparam int unsigned UnitW   = 16;
    localparam int unsigned ByteW   = 8;
    localparam int unsigned FifoDepth = 4;
    localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
    localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

    // lead byte thresholds
    localparam logic [ByteW-1:0] Lead4 = 8'hF0;
    localparam logic [ByteW-1:0] Lead3 = 8'hE0;
    localparam logic [ByteW-1:0] Lead2 = 8'hC0;
    localparam logic [ByteW-1:0] PayloadMask = 8'h3F;

    localparam logic [UnitW-1:0] CapacityReset = 16'hFFFF;

    // register index of capacity
    localparam logic RegCapacity = 1'b0;

    typedef enum logic [1:0] {
        ST_UNIT = 2'd0,
        ST_TERM = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic [UnitW-1:0] code_unit;
        logic [UnitW-1:0] position;
        t_status          status;
        logic             last;
    } t_result;

    // up to two results per input byte, first one always fills slot 0
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

endpackage

// ===== design/u8dec_core.sv =====
// ----------------------------------------------------------------------------
// u8dec_core
// per-byte decode step: sequence state, accumulator and unit count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "utf8_to_ucs2_decoder_top_assert.svh"

module u8dec_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [u8dec_pkg::UnitW-1:0] i_capacity,
    input  logic                      i_take,
    input  logic [u8dec_pkg::ByteW-1:0] i_byte,
    output u8dec_pkg::t_push          o_push
);

    logic [1:0]                  r_bytes_left, n_bytes_left;
    logic [u8dec_pkg::UnitW-1:0] r_acc, n_acc;
    logic [u8dec_pkg::UnitW-1:0] r_count, n_count;
    logic                        r_failed, n_failed;

    logic [u8dec_pkg::UnitW-1:0] acc_shift;
    logic [u8dec_pkg::UnitW-1:0] count_inc;
    logic                        full;
    logic                        zero_byte;
    logic [u8dec_pkg::ByteW-1:0] low_bits;
    u8dec_pkg::t_push            push;

    assign low_bits  = i_byte & u8dec_pkg::PayloadMask;
    assign acc_shift = {r_acc[u8dec_pkg::UnitW-7:0], 6'b0}
                     + {{(u8dec_pkg::UnitW-u8dec_pkg::ByteW){1'b0}}, low_bits};
    assign count_inc = r_count + 16'd1;
    assign full      = (count_inc >= i_capacity);
    assign zero_byte = (i_byte == '0);

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_acc        = r_acc;
        n_count      = r_count;
        n_failed     = r_failed;

        push.v0 = 1'b0;
        push.v1 = 1'b0;
        push.r0 = '{code_unit: acc_shift, position: r_count,
                    status: u8dec_pkg::ST_UNIT, last: 1'b0};
        push.r1 = '{code_unit: '0, position: '0,
                    status: u8dec_pkg::ST_FULL, last: 1'b1};

        if (r_failed) begin
            // drop bytes until the end of the string
            if (zero_byte) begin
                n_bytes_left = '0;
                n_acc        = '0;
                n_count      = '0;
                n_failed     = 1'b0;
            end
        end else if (r_bytes_left != 2'd0) begin
            if (zero_byte) begin
                // truncated sequence: flush the partial unit, then end
                push.v0 = 1'b1;
                push.v1 = 1'b1;
                if (!full) begin
                    push.r1 = '{code_unit: '0, position: count_inc,
                                status: u8dec_pkg::ST_TERM, last: 1'b1};
                end
                n_bytes_left = '0;
                n_acc        = '0;
                n_count      = '0;
                n_failed     = 1'b0;
            end else if (r_bytes_left == 2'd1) begin
                push.v0      = 1'b1;
                push.v1      = full;
                n_bytes_left = '0;
                n_acc        = '0;
                n_count      = count_inc;
                n_failed     = full;
            end else begin
                n_bytes_left = r_bytes_left - 2'd1;
                n_acc        = acc_shift;
            end
        end else begin
            priority if (zero_byte) begin
                push.v0 = 1'b1;
                push.r0 = '{code_unit: '0, position: r_count,
                            status: u8dec_pkg::ST_TERM, last: 1'b1};
                n_acc   = '0;
                n_count = '0;
            end else if (i_byte >= u8dec_pkg::Lead4) begin
                n_bytes_left = 2'd3;
                n_acc        = {{(u8dec_pkg::UnitW-u8dec_pkg::ByteW){1'b0}}, low_bits};
            end else if (i_byte >= u8dec_pkg::Lead3) begin
                n_bytes_left = 2'd2;
                n_acc        = {{(u8dec_pkg::UnitW-u8dec_pkg::ByteW){1'b0}}, low_bits};
            end else if (i_byte >= u8dec_pkg::Lead2) begin
                n_bytes_left = 2'd1;
                n_acc        = {{(u8dec_pkg::UnitW-u8dec_pkg::ByteW){1'b0}}, low_bits};
            end else begin
                // single byte unit, stray continuation bytes included
                push.v0 = 1'b1;
                push.v1 = full;
                push.r0.code_unit = {{(u8dec_pkg::UnitW-u8dec_pkg::ByteW){1'b0}}, i_byte};
                n_count  = count_inc;
                n_failed = full;
            end
        end

        if (!i_take) begin
            push.v0 = 1'b0;
            push.v1 = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_acc        <= '0;
            r_count      <= '0;
            r_failed     <= 1'b0;
        end else if (i_take) begin
            r_bytes_left <= n_bytes_left;
            r_acc        <= n_acc;
            r_count      <= n_count;
            r_failed     <= n_failed;
        end
    end

    assign o_push = push;

    `U8DEC_ASSERT_IMPLY(a_fail_idle, i_clk, i_rst_n, r_failed, (r_bytes_left == 2'd0) && (r_acc == '0))
    `U8DEC_ASSERT_IMPLY(a_second_is_last, i_clk, i_rst_n, push.v1, push.r1.last && push.v0)
    `U8DEC_ASSERT_NEXT(a_full_sets_fail, i_clk, i_rst_n, push.v1 && !zero_byte, r_failed)

endmodule

// ===== design/u8dec_fifo.sv =====
// ----------------------------------------------------------------------------
// u8dec_fifo
// small result queue taking up to two results per cycle, draining one
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "utf8_to_ucs2_decoder_top_assert.svh"

module u8dec_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  u8dec_pkg::t_push   i_push,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_ready,
    output u8dec_pkg::t_result o_result
);

    u8dec_pkg::t_result r_mem [u8dec_pkg::FifoDepth];

    logic [u8dec_pkg::FifoPtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [u8dec_pkg::FifoPtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [u8dec_pkg::FifoCntW-1:0] r_count, n_count;
    logic [u8dec_pkg::FifoPtrW-1:0] wr_ptr1;
    logic                           pop;
    logic [u8dec_pkg::FifoCntW-1:0] n_push;

    assign wr_ptr1 = r_wr_ptr + 1'b1;
    assign pop     = o_valid && i_ready;
    assign n_push  = u8dec_pkg::FifoCntW'(i_push.v0) + u8dec_pkg::FifoCntW'(i_push.v1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + u8dec_pkg::FifoPtrW'(n_push);
        n_rd_ptr = r_rd_ptr + u8dec_pkg::FifoPtrW'(pop);
        n_count  = r_count + n_push - u8dec_pkg::FifoCntW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[wr_ptr1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // room for a worst-case pair of results
    assign o_room   = (r_count <= u8dec_pkg::FifoCntW'(u8dec_pkg::FifoDepth - 2));
    assign o_valid  = (r_count != '0);
    assign o_result = r_mem[r_rd_ptr];

    `U8DEC_ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, i_push.v0, o_room)
    `U8DEC_ASSERT_IMPLY(a_pair_order, i_clk, i_rst_n, i_push.v1, i_push.v0)
    `U8DEC_ASSERT_NEXT(a_drain, i_clk, i_rst_n, pop && !i_push.v0, r_count == $past(r_count) - 1'b1)

endmodule

// ===== design/utf8_to_ucs2_decoder_top.sv =====
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder_top
// utf-8 byte stream in, 16-bit code units with buffer positions out
// ----------------------------------------------------------------------------
//
//   channel   | handshake                    | word
//   ----------+------------------------------+----------------------------------
//   in        | i_in_valid / o_in_ready      | i_in_byte
//   out       | o_out_valid / i_out_ready    | o_code_unit o_position o_status
//             |                              | o_last
//   config    | psel penable pwrite pready   | paddr pwdata prdata (capacity)
//
// one byte is taken per cycle while o_in_ready is high; the decode step is a
// single add and compare between the byte input and the result queue, which
// registers each word; the first word of a byte reaches the output once the
// words queued ahead of it have drained. a byte can produce two words (unit
// plus terminator or failure); the four-word result queue drains one word a
// cycle while i_out_ready is high, so bursts of such bytes slow the input to
// the output rate. o_in_ready drops while the queue lacks room for two words.
// synchronous active-low reset clears the sequence state, the queue and
// sets capacity to 65535.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "utf8_to_ucs2_decoder_top_assert.svh"

module utf8_to_ucs2_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // byte input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,

    // word output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_code_unit,
    output logic [15:0] o_position,
    output logic [1:0]  o_status,
    output logic        o_last,

    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [u8dec_pkg::UnitW-1:0] r_capacity;
    logic                        cfg_write;
    logic                        reg_sel;
    logic                        take;
    u8dec_pkg::t_push            push;
    u8dec_pkg::t_result          result;

    // ------------------------------------------------------------------
    // register port: capacity at byte addresses 0 to 3, writes elsewhere dropped
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= u8dec_pkg::CapacityReset;
        end else if (cfg_write && (reg_sel == u8dec_pkg::RegCapacity)) begin
            r_capacity <= pwdata[u8dec_pkg::UnitW-1:0];
        end
    end

    always_comb begin
        unique case (reg_sel)
            u8dec_pkg::RegCapacity: prdata = {16'b0, r_capacity};
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // decode step, fired on every accepted byte
    // ------------------------------------------------------------------
    assign take = i_in_valid && o_in_ready;

    u8dec_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_capacity (r_capacity),
        .i_take     (take),
        .i_byte     (i_in_byte),
        .o_push     (push)
    );

    // ------------------------------------------------------------------
    // result queue decouples the two-word bytes from the output side
    // ------------------------------------------------------------------
    u8dec_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (o_in_ready),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (result)
    );

    assign o_code_unit = result.code_unit;
    assign o_position  = result.position;
    assign o_status    = result.status;
    assign o_last      = result.last;

    // a failure word carries no unit and no position
    `U8DEC_ASSERT_IMPLY(a_full_word, i_clk, i_rst_n,
        o_out_valid && (o_status == u8dec_pkg::ST_FULL),
        (o_code_unit == '0) && (o_position == '0) && o_last)
    // last is set exactly on terminator and failure words
    `U8DEC_ASSERT_IMPLY(a_last_code, i_clk, i_rst_n,
        o_out_valid, o_last == (o_status != u8dec_pkg::ST_UNIT))
    // a stalled output word stays put
    `U8DEC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_code_unit) && $stable(o_position) && $stable(o_status))

endmodule
